// ----- src/lpr_pkg.sv -----
// Shared constants and types for the LRU page replacement block.
package lpr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int CFG_W   = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Wide enough to hold any clamped frame count up to 64.
    localparam int CNT_W   = 7;
    localparam int RANK_W  = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
    localparam int SLOT_W  = 4;
    localparam int FAULT_W = 32;
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic             final_ref;
        logic [CNT_W-1:0] active;
    } lpr_tag_t;

endpackage

// ----- src/lpr_front.sv -----
// Front end: frame-count register, input handshake and beat classification.
module lpr_front #(
    parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0] cfg_frames_in_use,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PAGE_BITS-1:0]     s_page,
    input  logic                     s_final_ref,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [PAGE_BITS-1:0]     q_page,
    output lpr_pkg::lpr_tag_t        q_tag
);

    logic [lpr_pkg::CFG_W-1:0] frames_in_use_reg;
    logic [lpr_pkg::CNT_W-1:0] cfg_wide;
    logic [lpr_pkg::CNT_W-1:0] active;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= lpr_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            frames_in_use_reg <= cfg_frames_in_use;
        end
    end

    // Clamp the frame count into 1..MAX_FRAMES.
    always_comb begin
        cfg_wide = lpr_pkg::CNT_W'(frames_in_use_reg);
        if (cfg_wide == '0) begin
            active = lpr_pkg::CNT_W'(1);
        end else if (cfg_wide > lpr_pkg::CNT_W'(MAX_FRAMES)) begin
            active = lpr_pkg::CNT_W'(MAX_FRAMES);
        end else begin
            active = cfg_wide;
        end
    end

    assign s_ready         = !q_full;
    assign q_push          = s_valid && !q_full;
    assign q_page          = s_page;
    assign q_tag.final_ref = s_final_ref;
    assign q_tag.active    = active;

endmodule

// ----- src/lpr_queue.sv -----
// Short FIFO between the front end and the frame table.
module lpr_queue #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] dout
);

    localparam int PTR_W = (lpr_pkg::Q_DEPTH > 1) ? $clog2(lpr_pkg::Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(lpr_pkg::Q_DEPTH + 1);

    logic [W-1:0]      mem_reg [lpr_pkg::Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_QW'(lpr_pkg::Q_DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lpr_pkg::Q_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lpr_pkg::Q_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- src/lpr_back.sv -----
// Back end: frame table lookup, LRU ranking, fault count and result register.
module lpr_back #(
    parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  logic [PAGE_BITS-1:0]        q_page,
    input  lpr_pkg::lpr_tag_t           q_tag,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [lpr_pkg::SLOT_W-1:0]  m_slot,
    output logic                        m_evicted_valid,
    output logic [PAGE_BITS-1:0]        m_evicted_page,
    output logic [lpr_pkg::FAULT_W-1:0] m_fault_total,
    output logic                        m_run_end
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANKS = 1 << lpr_pkg::RANK_W;
    localparam int LIM_W = lpr_pkg::RANK_W + 1;

    logic [PAGE_BITS-1:0]         page_reg  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0]        valid_reg, valid_next;
    logic [lpr_pkg::RANK_W-1:0]   rank_reg  [MAX_FRAMES];
    logic [lpr_pkg::RANK_W-1:0]   rank_next [MAX_FRAMES];
    logic [lpr_pkg::FAULT_W-1:0]  fault_reg, fault_step, fault_next;

    logic                         out_valid_reg;
    logic                         hit_reg;
    logic [lpr_pkg::SLOT_W-1:0]   slot_reg;
    logic                         ev_valid_reg;
    logic [PAGE_BITS-1:0]         ev_page_reg;
    logic [lpr_pkg::FAULT_W-1:0]  fault_out_reg;
    logic                         run_end_reg;

    logic [MAX_FRAMES-1:0]        in_use, match, free;
    logic [RANKS-1:0]             rank_seen;
    logic [lpr_pkg::RANK_W-1:0]   max_rank;
    logic [IDX_W-1:0]             hit_pos, free_pos, victim_pos, pos;
    logic                         hit, ev_valid;
    logic [PAGE_BITS-1:0]         ev_page;
    logic [LIM_W-1:0]             limit;
    logic [31:0]                  pos_wide;
    logic                         take;

    assign take  = !out_valid_reg || m_ready;
    assign q_pop = q_valid && take;

    always_comb begin
        in_use    = '0;
        match     = '0;
        free      = '0;
        rank_seen = '0;
        hit_pos   = '0;
        free_pos  = '0;
        victim_pos = '0;
        max_rank  = '0;
        for (int j = 0; j < MAX_FRAMES; j++) begin
            in_use[j] = lpr_pkg::CNT_W'(j) < q_tag.active;
            match[j]  = in_use[j] && valid_reg[j] && (page_reg[j] == q_page);
            free[j]   = in_use[j] && !valid_reg[j];
        end
        // Lowest index wins: scan downward so the last write is the lowest.
        for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit_pos = IDX_W'(j);
            end
            if (free[j]) begin
                free_pos = IDX_W'(j);
            end
        end
        for (int r = 0; r < RANKS; r++) begin
            for (int j = 0; j < MAX_FRAMES; j++) begin
                if (in_use[j] && rank_reg[j] == lpr_pkg::RANK_W'(r)) begin
                    rank_seen[r] = 1'b1;
                end
            end
        end
        for (int r = 0; r < RANKS; r++) begin
            if (rank_seen[r]) begin
                max_rank = lpr_pkg::RANK_W'(r);
            end
        end
        for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
            if (in_use[j] && rank_reg[j] == max_rank) begin
                victim_pos = IDX_W'(j);
            end
        end

        hit      = |match;
        ev_valid = !hit && !(|free);
        if (hit) begin
            pos = hit_pos;
        end else if (|free) begin
            pos = free_pos;
        end else begin
            pos = victim_pos;
        end
        ev_page  = ev_valid ? page_reg[victim_pos] : '0;
        pos_wide = 32'(pos);
        limit    = hit ? {1'b0, rank_reg[hit_pos]} : LIM_W'(RANKS);
    end

    // Next table state for the beat at the head of the queue.
    always_comb begin
        valid_next = valid_reg;
        for (int j = 0; j < MAX_FRAMES; j++) begin
            rank_next[j] = rank_reg[j];
            if (in_use[j] && valid_reg[j] && IDX_W'(j) != pos
                && {1'b0, rank_reg[j]} < limit && rank_reg[j] != lpr_pkg::RANK_MAX) begin
                rank_next[j] = rank_reg[j] + 1'b1;
            end
        end
        rank_next[pos]  = '0;
        valid_next[pos] = 1'b1;

        if (hit || fault_reg == '1) begin
            fault_step = fault_reg;
        end else begin
            fault_step = fault_reg + 1'b1;
        end
        fault_next = fault_step;

        // Close the run: drop all frames, ranks and the count.
        if (q_tag.final_ref) begin
            valid_next = '0;
            fault_next = '0;
            for (int j = 0; j < MAX_FRAMES; j++) begin
                rank_next[j] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_FRAMES; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            if (q_pop) begin
                valid_reg <= valid_next;
                fault_reg <= fault_next;
                for (int j = 0; j < MAX_FRAMES; j++) begin
                    rank_reg[j] <= rank_next[j];
                end
            end
            if (q_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            page_reg[pos] <= q_page;
            hit_reg       <= hit;
            slot_reg      <= pos_wide[lpr_pkg::SLOT_W-1:0];
            ev_valid_reg  <= ev_valid;
            ev_page_reg   <= ev_page;
            fault_out_reg <= fault_step;
            run_end_reg   <= q_tag.final_ref;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = hit_reg;
    assign m_slot          = slot_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_page  = ev_page_reg;
    assign m_fault_total   = fault_out_reg;
    assign m_run_end       = run_end_reg;

endmodule

// ----- src/lru_page_replacement_top.sv -----
// Top level of the LRU page replacement block.
//
//  channel | direction | handshake            | beat carries
//  --------+-----------+----------------------+-------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_frames_in_use
//  s       | in        | s_valid/s_ready      | s_page, s_final_ref
//  m       | out       | m_valid/m_ready      | m_hit, m_slot, m_evicted_valid,
//          |           |                      | m_evicted_page, m_fault_total, m_run_end
//
// One reference per cycle sustained while m_ready is held high; each beat is written into the
// queue, sits at the queue head while the frame table is searched, then lands in the
// result register that drives m_valid.
// The frame table compare, rank update and victim pick are combinational.
// Reset is synchronous, active low; frames, ranks, count and queue are empty after it.
// A stalled m side fills the queue, after which s_ready drops; cfg_ready is always high.
module lru_page_replacement_top #(
    parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]   cfg_frames_in_use,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [PAGE_BITS-1:0]        s_page,
    input  logic                        s_final_ref,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [lpr_pkg::SLOT_W-1:0]  m_slot,
    output logic                        m_evicted_valid,
    output logic [PAGE_BITS-1:0]        m_evicted_page,
    output logic [lpr_pkg::FAULT_W-1:0] m_fault_total,
    output logic                        m_run_end
);

    localparam int QW = PAGE_BITS + $bits(lpr_pkg::lpr_tag_t);

    logic                  q_push, q_full, q_pop, q_valid;
    logic [PAGE_BITS-1:0]  f_page, b_page;
    lpr_pkg::lpr_tag_t     f_tag, b_tag;
    logic [QW-1:0]         q_dout;

    lpr_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_frames_in_use (cfg_frames_in_use),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_page            (s_page),
        .s_final_ref       (s_final_ref),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_page            (f_page),
        .q_tag             (f_tag)
    );

    lpr_queue #(
        .W (QW)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     ({f_page, f_tag}),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_dout)
    );

    assign b_page = q_dout[QW-1 -: PAGE_BITS];
    assign b_tag  = q_dout[$bits(lpr_pkg::lpr_tag_t)-1:0];

    lpr_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_page          (b_page),
        .q_tag           (b_tag),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_slot          (m_slot),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_total   (m_fault_total),
        .m_run_end       (m_run_end)
    );

endmodule

// ----- src/lpr_checker.sv -----
// Port-level checks for the LRU page replacement block, bound to the top level.
module lpr_checker #(
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_hit,
    input logic [lpr_pkg::SLOT_W-1:0]  m_slot,
    input logic                        m_evicted_valid,
    input logic [PAGE_BITS-1:0]        m_evicted_page,
    input logic [lpr_pkg::FAULT_W-1:0] m_fault_total
);

    // A held result beat keeps its slot and fault total.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_slot) && $stable(m_fault_total))
        else $error("result beat changed while stalled");

    // A fault is counted in its own beat, so the total cannot be zero.
    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_fault_total != '0)
        else $error("fault reported with zero fault total");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted_valid)
        else $error("eviction reported on a hit");

    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> m_evicted_page == '0)
        else $error("evicted page nonzero without an eviction");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind lru_page_replacement_top lpr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_lpr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_hit           (m_hit),
    .m_slot          (m_slot),
    .m_evicted_valid (m_evicted_valid),
    .m_evicted_page  (m_evicted_page),
    .m_fault_total   (m_fault_total)
);
